// ===== src/cwfd_pkg.sv =====
package cwfd_pkg;

    localparam int VALUE_COUNT_DEF = 3;
    localparam int VALUE_COUNT_MAX = 8;
    localparam int WORD_BYTES      = 2;
    localparam int GROUP_BYTES     = 3;
    localparam int VALUE_BYTES     = 6;
    localparam int IDX_W           = $clog2(VALUE_COUNT_MAX);
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] CHECK_INIT = 8'hFF;
    localparam logic [7:0] CHECK_POLY = 8'h31;
    localparam logic [7:0] CHECK_TOP  = 8'h80;

    typedef logic [7:0] byte_t;

    typedef enum logic [0:0] {
        KIND_DATA  = 1'b0,
        KIND_CHECK = 1'b1
    } kind_t;

    // one classified word on its way from front to back
    typedef struct packed {
        byte_t            data;
        kind_t            kind;
        logic [IDX_W-1:0] idx;
        logic             clear;
        logic             last;
    } entry_t;

    // CRC-8, MSB first, one byte
    function automatic byte_t crc8_update(input byte_t crc, input byte_t data);
        byte_t c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CHECK_TOP) != 8'h00)
                c = (c << 1) ^ CHECK_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

// ===== src/cwfd_front.sv =====
module cwfd_front #(
    parameter int VALUE_COUNT = cwfd_pkg::VALUE_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  cwfd_pkg::byte_t   in_data,
    input  logic              in_start,
    input  logic              queue_full,
    output logic              in_ready,
    output logic              push,
    output cwfd_pkg::entry_t  push_entry
);
    import cwfd_pkg::*;

    localparam int FRAME_BYTES = VALUE_COUNT * VALUE_BYTES;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next, pos_cur;
    logic [1:0]       phase_reg, phase_next, phase_cur;
    logic [2:0]       vbyte_reg, vbyte_next, vbyte_cur;
    logic [IDX_W-1:0] idx_reg, idx_next, idx_cur;
    logic             last;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    // frame_start restarts counting at this word
    assign pos_cur   = in_start ? '0 : pos_reg;
    assign phase_cur = in_start ? '0 : phase_reg;
    assign vbyte_cur = in_start ? '0 : vbyte_reg;
    assign idx_cur   = in_start ? '0 : idx_reg;
    assign last      = (pos_cur == POS_W'(FRAME_BYTES - 1));

    always_comb
    begin
        push_entry.data  = in_data;
        push_entry.kind  = (phase_cur == 2'(GROUP_BYTES - 1)) ? KIND_CHECK : KIND_DATA;
        push_entry.idx   = idx_cur;
        push_entry.clear = in_start;
        push_entry.last  = last;

        if (last)
        begin
            pos_next   = '0;
            phase_next = '0;
            vbyte_next = '0;
            idx_next   = '0;
        end
        else
        begin
            pos_next   = pos_cur + 1'b1;
            phase_next = (phase_cur == 2'(GROUP_BYTES - 1)) ? 2'd0 : phase_cur + 2'd1;
            if (vbyte_cur == 3'(VALUE_BYTES - 1))
            begin
                vbyte_next = '0;
                idx_next   = idx_cur + 1'b1;
            end
            else
            begin
                vbyte_next = vbyte_cur + 3'd1;
                idx_next   = idx_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= '0;
            vbyte_reg <= '0;
            idx_reg   <= '0;
        end
        else if (push)
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            vbyte_reg <= vbyte_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== src/cwfd_queue.sv =====
module cwfd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cwfd_pkg::entry_t  push_entry,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output cwfd_pkg::entry_t  head
);
    import cwfd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t           slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
        end
    end

endmodule

// ===== src/cwfd_back.sv =====
module cwfd_back #(
    parameter int VALUE_COUNT = cwfd_pkg::VALUE_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  cwfd_pkg::entry_t  head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [95:0]       out_data,
    output logic              out_status
);
    import cwfd_pkg::*;

    cwfd_pkg::byte_t crc_reg, crc_next, crc_base;
    logic            failed_reg, failed_base, failed_next;
    logic [31:0]     values_reg [VALUE_COUNT];
    logic [31:0]     field [3];
    logic            out_valid_reg;
    logic [95:0]     out_data_reg;
    logic            out_status_reg;
    logic            load;

    // a frame's last word may only leave the queue when the output slot is free
    assign pop  = !empty && (!head.last || !out_valid_reg || out_ready);
    assign load = pop && head.last;

    assign crc_base    = head.clear ? CHECK_INIT : crc_reg;
    assign failed_base = head.clear ? 1'b0 : failed_reg;

    always_comb
    begin
        crc_next    = crc_base;
        failed_next = failed_base;
        unique case (head.kind)
            KIND_DATA:
            begin
                crc_next = crc8_update(crc_base, head.data);
            end
            KIND_CHECK:
            begin
                crc_next    = CHECK_INIT;
                failed_next = failed_base | (head.data != crc_base);
            end
            default:
            begin
                crc_next = crc_base;
            end
        endcase
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_field
        if (j < VALUE_COUNT)
        begin : g_used
            assign field[j] = failed_next ? 32'h0 : values_reg[j];
        end
        else
        begin : g_unused
            assign field[j] = 32'h0;
        end
    end

    for (genvar k = 0; k < VALUE_COUNT; k++)
    begin : g_store
        always_ff @(posedge clk)
        begin
            if (pop && head.kind == KIND_DATA && head.idx == IDX_W'(k))
                values_reg[k] <= {values_reg[k][23:0], head.data};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CHECK_INIT;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                crc_reg    <= load ? CHECK_INIT : crc_next;
                failed_reg <= load ? 1'b0 : failed_next;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg   <= {field[2], field[1], field[0]};
            out_status_reg <= failed_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

endmodule

// ===== src/crc_checked_word_frame_deframer.sv =====
// Result: a frame's last word is registered in the queue slot and then in the output
//   register before its result is valid; a result still held by m_tready low delays it.
// Throughput: one byte word per cycle while the queue is not full; the CRC-8 update is
//   one unrolled byte step in the back end, and a two-entry queue parts front and back.
// Reset: rst_n is asynchronous, active low; it clears the byte position, the
//   running CRC (to 0xFF), the error mark, the queue and the output valid.
module crc_checked_word_frame_deframer #(
    parameter int VALUE_COUNT = cwfd_pkg::VALUE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream: one received byte per word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] frame_start
    // result stream: one word per complete frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [31:0] first_value_bits, [63:32] second_value_bits,
                                   // [95:64] third_value_bits
    output logic        m_tuser    // [0] frame_status (1 = CRC mismatch)
);
    import cwfd_pkg::*;

    // front: tracks position in the frame and tags each byte as data or check
    // queue: short buffer so the front keeps taking bytes while a result waits
    // back:  runs the CRC per 2-byte word, assembles big-endian values, emits

    logic   push;
    logic   pop;
    logic   queue_full;
    logic   queue_empty;
    entry_t push_entry;
    entry_t head;

    cwfd_front #(
        .VALUE_COUNT (VALUE_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_data    (s_tdata),
        .in_start   (s_tuser),
        .queue_full (queue_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    cwfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .empty      (queue_empty),
        .head       (head)
    );

    // values are zeroed on output when any word check failed
    cwfd_back #(
        .VALUE_COUNT (VALUE_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (queue_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );

endmodule

// ===== tb/tb_crc_checked_word_frame_deframer.sv =====
package tb_cwfd_check_pkg;

    import cwfd_pkg::*;

    localparam int FRAME_BYTES   = VALUE_COUNT_DEF * VALUE_BYTES;
    localparam int PAYLOAD_BYTES = VALUE_COUNT_DEF * 2 * WORD_BYTES;

    typedef struct packed {
        logic [95:0] values;    // {third, second, first}
        logic        crc_error;
    } frame_result_t;

    // CRC-8, poly 0x31, MSB first
    function automatic logic [7:0] poly31_byte_step(input logic [7:0] crc,
                                                    input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (r[7])
                r = {r[6:0], 1'b0} ^ CHECK_POLY;
            else
                r = {r[6:0], 1'b0};
        end
        return r;
    endfunction

    class frame_scoreboard;

        int            pos;
        logic [7:0]    word_crc;
        logic          failed;
        logic [31:0]   vals [VALUE_COUNT_DEF];
        frame_result_t expected_frames [$];
        int            errors;
        int            frames_clean;
        int            frames_failed;
        string         field_name [3];

        function new();
            field_name[0] = "first_value_bits";
            field_name[1] = "second_value_bits";
            field_name[2] = "third_value_bits";
            errors        = 0;
            frames_clean  = 0;
            frames_failed = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos      = 0;
            word_crc = CHECK_INIT;
            failed   = 1'b0;
            foreach (vals[i])
                vals[i] = '0;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        // update the frame state with one accepted byte
        function void note_byte(input logic [7:0] b, input logic start);
            frame_result_t r;
            int            idx;
            if (start)
                clear_frame();
            if ((pos % GROUP_BYTES) < WORD_BYTES)
            begin
                word_crc = poly31_byte_step(word_crc, b);
                idx = pos / VALUE_BYTES;
                if (idx < VALUE_COUNT_DEF)
                    vals[idx] = {vals[idx][23:0], b};
            end
            else
            begin
                if (b != word_crc)
                    failed = 1'b1;
                word_crc = CHECK_INIT;
            end
            pos++;
            if (pos == FRAME_BYTES)
            begin
                r.values    = failed ? 96'd0 : {vals[2], vals[1], vals[0]};
                r.crc_error = failed;
                expected_frames.push_back(r);
                clear_frame();
            end
        endfunction

        task report(input string msg);
            errors++;
            $display("[%0t] ERROR: %s", $time, msg);
        endtask

        task check_frame(input logic [95:0] got_values, input logic got_status);
            frame_result_t e;
            if (expected_frames.size() == 0)
            begin
                report($sformatf("unexpected result %h status %b", got_values, got_status));
                return;
            end
            e = expected_frames.pop_front();
            if (e.crc_error)
                frames_failed++;
            else
                frames_clean++;
            for (int f = 0; f < 3; f++)
            begin
                if (got_values[f*32 +: 32] !== e.values[f*32 +: 32])
                    report($sformatf("%s got %h expected %h", field_name[f],
                                     got_values[f*32 +: 32], e.values[f*32 +: 32]));
            end
            if (got_status !== e.crc_error)
                report($sformatf("frame_status got %b expected %b", got_status, e.crc_error));
        endtask

    endclass

endpackage

module tb_crc_checked_word_frame_deframer;

    timeunit 1ns;
    timeprecision 1ps;

    import cwfd_pkg::*;
    import tb_cwfd_check_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_BYTES  = 1500;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;    // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;           // [31:0] first, [63:32] second, [95:64] third value
    logic        m_tuser;           // [0] frame_status

    frame_scoreboard sb;

    int cycles = 0;
    int bytes_sent = 0;
    int frames_aborted = 0;
    bit tx_calm = 1'b0;     // sender runs back to back while set
    bit rx_calm = 1'b0;     // receiver always ready while set, unless a long hold is asked
    bit hold_req = 1'b0;    // asks the receiver for one long stall

    crc_checked_word_frame_deframer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Outputs are sampled right after the edge, so they still hold the values
    // the DUT presented at the edge itself.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_frame(m_tdata, m_tuser);
    end

    // Receiver: random stall per result, calm stretches, and one long hold
    // on request so the output backs up into the input queue.
    initial
    begin
        int gap;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 5) == 0)
                rx_calm = ~rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 18);
            if (hold_req)
            begin
                gap = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Offer one byte, optionally after a random gap, and hold it until taken.
    // valid stays high across back-to-back bytes.
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(b, start);
        bytes_sent++;
    endtask

    // Send the first len bytes of a frame: payload bytes in word slots, the
    // proper CRC in check slots, with the check of bad_group corrupted.
    task automatic send_frame(input logic [7:0] payload [PAYLOAD_BYTES], input bit with_start,
                              input int len, input int bad_group);
        logic [7:0] crc;
        logic [7:0] b;
        logic [7:0] flip;
        int         k;
        crc  = CHECK_INIT;
        k    = 0;
        flip = 8'($urandom_range(1, 255));
        for (int p = 0; p < len; p++)
        begin
            if ((p % GROUP_BYTES) < WORD_BYTES)
            begin
                b = payload[k];
                k++;
                crc = poly31_byte_step(crc, b);
            end
            else
            begin
                b = crc;
                if (p / GROUP_BYTES == bad_group)
                    b = b ^ flip;
                crc = CHECK_INIT;
            end
            send_byte(b, with_start && (p == 0));
        end
    endtask

    // sender pause: drop valid and let every pending result drain
    task automatic drain_results();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // payload bytes lean toward the corner values
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h01;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        logic [7:0] payload [PAYLOAD_BYTES];
        logic [7:0] partial [PAYLOAD_BYTES];
        bit         need_start;
        int         kind;
        int         frame_no;
        int         n;

        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a clean frame of corner values with frame_start on byte 0
        // (a start at position 0 that changes nothing), values
        // FFFF0000 / 80000001 / FF0000FF.
        payload = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h00,
                    8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'hFF};
        tx_calm = 1'b1;
        send_frame(payload, 1'b1, FRAME_BYTES, -1);
        // Right after the end of frame: bytes with no frame_start begin a new
        // frame, which the first random frame then restarts mid-word group.
        partial = '{8'hAA, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        tx_calm = 1'b0;
        send_frame(partial, 1'b0, 4, -1);
        need_start = 1'b1;
        drain_results();

        frame_no = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            foreach (payload[i])
                payload[i] = pick_byte();
            tx_calm = ($urandom_range(0, 3) == 0);
            if (frame_no == 12)
            begin
                // receiver stalls long while bytes keep coming back to back
                hold_req = 1'b1;
                tx_calm  = 1'b1;
            end
            if (frame_no == 13 || frame_no == 14)
                tx_calm = 1'b1;
            if (frame_no == 40)
                drain_results();
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                // clean frame, start mark optional once aligned
                send_frame(payload, need_start || ($urandom_range(0, 3) != 0),
                           FRAME_BYTES, -1);
                need_start = 1'b0;
            end
            else if (kind <= 7)
            begin
                // one word check off
                send_frame(payload, need_start || ($urandom_range(0, 3) != 0),
                           FRAME_BYTES, $urandom_range(0, FRAME_BYTES / GROUP_BYTES - 1));
                need_start = 1'b0;
            end
            else if (kind == 8)
            begin
                // frame cut short, the next one restarts it
                send_frame(payload, 1'b1, $urandom_range(1, FRAME_BYTES - 1), -1);
                frames_aborted++;
                need_start = 1'b1;
            end
            else
            begin
                // loose bytes with random start marks
                n = $urandom_range(1, 6);
                repeat (n)
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                need_start = 1'b1;
            end
            frame_no++;
        end

        drain_results();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d frame results never arrived", sb.pending()));

        $display("%0d bytes sent in %0d frames, %0d cut short; %0d results checked",
                 bytes_sent, frame_no, frames_aborted, sb.frames_clean + sb.frames_failed);
        $display("%0d results clean, %0d flagged CRC error, %0d mismatches",
                 sb.frames_clean, sb.frames_failed, sb.errors);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
